@@ rtl/core/histeq_pkg.sv @@
// ----------------------------------------------------------------------------
// histeq_pkg
// Shared widths, codes and controller/datapath interface types for the
// histogram equalization table core.
// ----------------------------------------------------------------------------
package histeq_pkg;

  localparam int unsigned LEVELS    = 256;
  localparam int unsigned IDX_W     = $clog2(LEVELS);
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned TOT_W     = 2 * DIM_W;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned PROD_W    = SUM_W + OUT_W;
  localparam int unsigned NUM_W     = PROD_W + 2;
  localparam int unsigned DIV_STEPS = OUT_W + 1;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OUT_W-1:0] MAX_LEVEL = OUT_W'(LEVELS - 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic load_acc;
    logic query_acc;
    logic prep;
    logic num;
    logic div_run;
    logic div_first;
    logic div_last;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic ge;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/histogram_equalization_table_core.sv @@
// ----------------------------------------------------------------------------
// histogram_equalization_table_core
// Builds an 8-bit equalization table from a 256-bin histogram and answers
// single-entry queries.
//
// Usage: write image width (index 0) and height (index 1) on the config
// channel while the core is idle; cfg_ready_o is always high. Then send load
// items (operation 0) with bins in order from index 0; bin 0 restarts the
// build. Loads produce no result and are taken one per cycle unless a query
// is in progress. A query item (operation 1) yields one table_value on the
// output channel. Trivial cases (empty histogram, entry at or below the
// first bin, first count above the image size, single-level image) end
// after preparation; the others run the numerator build and the 9-step serial
// restoring division, which stops early on saturation; input stalls meanwhile.
// One result waits in the output register: a new item is taken while it
// waits, but a finishing query holds until the receiver drops out_stall_i.
// Reset sets width and height to 1 and clears the first-bin tracking and the
// running sum; the per-bin store is defined only for bins loaded since.
// ----------------------------------------------------------------------------
module histogram_equalization_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [histeq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [histeq_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [histeq_pkg::IDX_W-1:0]      bin_index_i,
  input  logic [histeq_pkg::CNT_W-1:0]      bin_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [histeq_pkg::OUT_W-1:0]      table_value_o
);

  histeq_pkg::cmd_t cmd;
  histeq_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  histeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  histeq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .bin_index_i   (bin_index_i),
    .bin_count_i   (bin_count_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .table_value_o (table_value_o)
  );

  // an accepted query holds off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == histeq_pkg::OP_QUERY) |=> in_stall_o)
    else $error("query accepted without stalling input");

  // no result appears right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared without query processing");

  // a load never leaves the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == histeq_pkg::OP_LOAD) |=> !in_stall_o)
    else $error("load item left core busy");

endmodule

@@ rtl/core/histeq_ctrl.sv @@
// ----------------------------------------------------------------------------
// histeq_ctrl
// Sequencer for the table core: takes items, steps the query datapath
// through preparation and, outside the trivial cases, numerator build and
// the serial division, then hands the result to the output register.
// ----------------------------------------------------------------------------
module histeq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  output logic              in_stall_o,
  input  histeq_pkg::sts_t  sts_i,
  output histeq_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_NUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [histeq_pkg::STEP_W-1:0] step_q, step_d;
  logic idle;
  logic first;
  logic last;

  assign idle  = (state_q == ST_IDLE);
  assign first = (step_q == '0);
  assign last  = (step_q == histeq_pkg::STEP_W'(histeq_pkg::DIV_STEPS - 1));

  assign in_stall_o = !idle;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_acc  = idle && in_valid_i && (operation_i == histeq_pkg::OP_LOAD);
    cmd_o.query_acc = idle && in_valid_i && (operation_i == histeq_pkg::OP_QUERY);
    cmd_o.prep      = (state_q == ST_PREP);
    cmd_o.num       = (state_q == ST_NUM);
    cmd_o.div_run   = (state_q == ST_DIV);
    cmd_o.div_first = first;
    cmd_o.div_last  = last;
    cmd_o.push      = (state_q == ST_FIN) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.query_acc) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = sts_i.special ? ST_FIN : ST_NUM;
      end
      ST_NUM: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        if ((first && sts_i.ge) || last) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ rtl/core/histeq_dp.sv @@
// ----------------------------------------------------------------------------
// histeq_dp
// Datapath of the table core: size registers, first-bin tracking, running
// sum and its per-bin store, numerator build, restoring divider with
// saturation and the output register.
// ----------------------------------------------------------------------------
module histeq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [histeq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [histeq_pkg::DIM_W-1:0]        cfg_data_i,
  input  logic [histeq_pkg::IDX_W-1:0]        bin_index_i,
  input  logic [histeq_pkg::CNT_W-1:0]        bin_count_i,
  input  histeq_pkg::cmd_t                    cmd_i,
  output histeq_pkg::sts_t                    sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [histeq_pkg::OUT_W-1:0]        table_value_o
);

  logic [histeq_pkg::DIM_W-1:0]  width_q, height_q;
  logic [histeq_pkg::SUM_W-1:0]  sum_q;
  logic                          found_q;
  logic [histeq_pkg::IDX_W-1:0]  level_q;
  logic [histeq_pkg::CNT_W-1:0]  fcount_q;

  logic                          base_found;
  logic [histeq_pkg::SUM_W-1:0]  base_sum;
  logic [histeq_pkg::SUM_W-1:0]  sum_add;
  logic                          found_d;
  logic [histeq_pkg::IDX_W-1:0]  level_d;
  logic [histeq_pkg::CNT_W-1:0]  fcount_d;
  logic [histeq_pkg::SUM_W-1:0]  sum_d;
  logic [histeq_pkg::SUM_W-1:0]  wdata;

  logic [histeq_pkg::SUM_W-1:0]  mem [histeq_pkg::LEVELS];
  logic [histeq_pkg::SUM_W-1:0]  rd_q;

  logic [histeq_pkg::IDX_W-1:0]  idx_q;
  logic [histeq_pkg::TOT_W-1:0]  total_q;
  logic [histeq_pkg::PROD_W-1:0] prod_q;
  logic [histeq_pkg::TOT_W-1:0]  denom_q;
  logic [histeq_pkg::NUM_W-1:0]  rem_q;
  logic [histeq_pkg::NUM_W-1:0]  div_q;
  logic [histeq_pkg::OUT_W-1:0]  quo_q;
  logic [histeq_pkg::OUT_W-1:0]  res_q;
  logic                          out_valid_q;
  logic [histeq_pkg::OUT_W-1:0]  table_q;

  logic                          is_eq, is_gt, is_le;
  logic                          special;
  logic [histeq_pkg::OUT_W-1:0]  special_val;
  logic                          ge;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= histeq_pkg::DIM_W'(1);
      height_q <= histeq_pkg::DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        histeq_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        histeq_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bin load: bin 0 restarts the build
  always_comb begin
    base_found = (bin_index_i == '0) ? 1'b0 : found_q;
    base_sum   = (bin_index_i == '0) ? '0 : sum_q;
    sum_add    = base_sum + histeq_pkg::SUM_W'(bin_count_i);
    found_d    = base_found;
    level_d    = (bin_index_i == '0) ? '0 : level_q;
    fcount_d   = (bin_index_i == '0) ? '0 : fcount_q;
    sum_d      = base_sum;
    wdata      = '0;
    if (!base_found) begin
      if (bin_count_i != '0) begin
        found_d  = 1'b1;
        level_d  = bin_index_i;
        fcount_d = bin_count_i;
      end
    end else begin
      sum_d = sum_add;
      wdata = sum_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      found_q  <= 1'b0;
      level_q  <= '0;
      fcount_q <= '0;
    end else if (cmd_i.load_acc) begin
      sum_q    <= sum_d;
      found_q  <= found_d;
      level_q  <= level_d;
      fcount_q <= fcount_d;
    end
  end

  // running sum store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_acc) mem[bin_index_i] <= wdata;
    if (cmd_i.query_acc) rd_q <= mem[bin_index_i];
  end

  // special cases
  assign is_eq = (fcount_q == total_q);
  assign is_gt = (fcount_q > total_q);
  assign is_le = (idx_q <= level_q);

  always_comb begin
    special     = 1'b1;
    special_val = '0;
    if (!found_q) begin
      special_val = '0;
    end else if (is_eq) begin
      special_val = histeq_pkg::OUT_W'(level_q);
    end else if (is_le) begin
      special_val = '0;
    end else if (is_gt) begin
      special_val = histeq_pkg::MAX_LEVEL;
    end else begin
      special = 1'b0;
    end
  end

  assign ge = (rem_q >= div_q);

  // query datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_acc) begin
      idx_q   <= bin_index_i;
      total_q <= histeq_pkg::TOT_W'(width_q) * histeq_pkg::TOT_W'(height_q);
    end
    if (cmd_i.prep) begin
      prod_q  <= {rd_q, 8'b0} - {8'b0, rd_q};
      denom_q <= total_q - fcount_q;
      if (special) res_q <= special_val;
    end
    if (cmd_i.num) begin
      rem_q <= {1'b0, prod_q, 1'b0} + {{(histeq_pkg::NUM_W - histeq_pkg::TOT_W){1'b0}}, denom_q};
      div_q <= {{(histeq_pkg::NUM_W - histeq_pkg::TOT_W - histeq_pkg::DIV_STEPS){1'b0}},
                denom_q, {histeq_pkg::DIV_STEPS{1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.div_run) begin
      div_q <= div_q >> 1;
      if (cmd_i.div_first) begin
        if (ge) res_q <= histeq_pkg::MAX_LEVEL;
      end else begin
        if (ge) rem_q <= rem_q - div_q;
        quo_q <= {quo_q[histeq_pkg::OUT_W-2:0], ge};
        if (cmd_i.div_last) res_q <= {quo_q[histeq_pkg::OUT_W-2:0], ge};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) table_q <= res_q;
  end

  assign sts_o.special  = special;
  assign sts_o.ge       = ge;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign table_value_o = table_q;

endmodule

@@ bench/histeq_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histeq_table_checker
// Watches the config, input and output channels of the equalization table
// core. It keeps its own copy of the bin sums and image size, works out the
// table entry for every accepted query and compares the core's results with
// them in order. It reports the failure count and the results still owed.
// ----------------------------------------------------------------------------
module histeq_table_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [histeq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [histeq_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              operation_i,
  input  logic [histeq_pkg::IDX_W-1:0]      bin_index_i,
  input  logic [histeq_pkg::CNT_W-1:0]      bin_count_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [histeq_pkg::OUT_W-1:0]      table_value_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  logic [histeq_pkg::SUM_W-1:0] sum_store [histeq_pkg::LEVELS];
  logic [histeq_pkg::SUM_W-1:0] run_sum;
  logic                         lead_seen;
  logic [histeq_pkg::IDX_W-1:0] lead_level;
  logic [histeq_pkg::CNT_W-1:0] lead_count;
  logic [histeq_pkg::DIM_W-1:0] img_w;
  logic [histeq_pkg::DIM_W-1:0] img_h;
  logic [histeq_pkg::OUT_W-1:0] level_queue [$];
  logic [histeq_pkg::OUT_W-1:0] oldest_level;
  int                           mismatches;

  function automatic logic [histeq_pkg::OUT_W-1:0] equalized_level(
    input logic [histeq_pkg::IDX_W-1:0] idx
  );
    logic [63:0] total;
    logic [63:0] denom;
    logic [63:0] num;
    logic [63:0] quot;
    total = 64'(img_w) * 64'(img_h);
    if (!lead_seen) return '0;
    if (64'(lead_count) == total) return lead_level;
    if (idx <= lead_level) return '0;
    if (64'(lead_count) > total) return histeq_pkg::MAX_LEVEL;
    denom = total - 64'(lead_count);
    num   = 64'(histeq_pkg::MAX_LEVEL) * 64'(sum_store[idx]) * 64'd2 + denom;
    quot  = num / (64'd2 * denom);
    if (quot > 64'(histeq_pkg::MAX_LEVEL)) quot = 64'(histeq_pkg::MAX_LEVEL);
    return quot[histeq_pkg::OUT_W-1:0];
  endfunction

  task automatic apply_load(input logic [histeq_pkg::IDX_W-1:0] idx,
                            input logic [histeq_pkg::CNT_W-1:0] cnt);
    if (idx == '0) begin
      run_sum    = '0;
      lead_seen  = 1'b0;
      lead_level = '0;
      lead_count = '0;
    end
    if (!lead_seen) begin
      if (cnt != '0) begin
        lead_seen  = 1'b1;
        lead_level = idx;
        lead_count = cnt;
      end
      sum_store[idx] = '0;
    end else begin
      run_sum        = run_sum + histeq_pkg::SUM_W'(cnt);
      sum_store[idx] = run_sum;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum    = '0;
      lead_seen  = 1'b0;
      lead_level = '0;
      lead_count = '0;
      img_w      = histeq_pkg::DIM_W'(1);
      img_h      = histeq_pkg::DIM_W'(1);
      mismatches = 0;
      level_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          histeq_pkg::REG_WIDTH: begin
            img_w = cfg_data_i;
          end
          histeq_pkg::REG_HEIGHT: begin
            img_h = cfg_data_i;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (level_queue.size() == 0) begin
          mismatches++;
          $error("table_value: unexpected item, expected none, actual %0d", table_value_i);
        end else begin
          oldest_level = level_queue.pop_front();
          if (table_value_i !== oldest_level) begin
            mismatches++;
            $error("table_value mismatch: expected %0d, actual %0d",
                   oldest_level, table_value_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == histeq_pkg::OP_QUERY) begin
          level_queue.push_back(equalized_level(bin_index_i));
        end else begin
          apply_load(bin_index_i, bin_count_i);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= level_queue.size();
    end
  end

endmodule

@@ bench/tb_histogram_equalization_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_equalization_table_core
// Drives the equalization table core with a short directed sequence and then
// with random frames: image sizes, histograms of several shapes loaded bin by
// bin or at random, queries of table entries, random input gaps and output
// stalls. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_histogram_equalization_table_core;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 2000;
  localparam int CALM_AFTER    = 1800;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {
    HIST_SPREAD,
    HIST_SINGLE,
    HIST_EMPTY,
    HIST_NOISE,
    HIST_BROKEN
  } hist_kind_e;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [histeq_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [histeq_pkg::DIM_W-1:0]     cfg_data_i  = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic                             operation_i = histeq_pkg::OP_LOAD;
  logic [histeq_pkg::IDX_W-1:0]     bin_index_i = '0;
  logic [histeq_pkg::CNT_W-1:0]     bin_count_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [histeq_pkg::OUT_W-1:0]     table_value_o;

  int                           fail_count;
  int                           pending;
  int                           cycle_count = 0;
  int                           items_sent  = 0;
  int                           gap_rate    = 0;
  int                           stall_rate  = 0;
  int                           stall_left  = 0;
  bit                           calm        = 1'b0;
  bit                           written [histeq_pkg::LEVELS];
  bit                           any_written = 1'b0;
  logic [histeq_pkg::IDX_W-1:0] last_loaded = '0;
  logic [histeq_pkg::DIM_W-1:0] frame_w     = histeq_pkg::DIM_W'(1);
  logic [histeq_pkg::DIM_W-1:0] frame_h     = histeq_pkg::DIM_W'(1);

  always #10 clk_i = ~clk_i;

  histogram_equalization_table_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .bin_index_i  (bin_index_i),
    .bin_count_i  (bin_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .table_value_o(table_value_o)
  );

  histeq_table_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .operation_i  (operation_i),
    .bin_index_i  (bin_index_i),
    .bin_count_i  (bin_count_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .table_value_i(table_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** histogram_equalization_table_core: FAILED **");
      $finish;
    end
  end

  // output stall bursts, started at random outside the calm phase
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
      stall_left  <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_item(input logic op, input logic [histeq_pkg::IDX_W-1:0] idx,
                           input logic [histeq_pkg::CNT_W-1:0] cnt);
    bit go;
    if (!calm && gap_rate != 0 && $urandom_range(0, 15) < gap_rate) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    bin_index_i <= idx;
    bin_count_i <= cnt;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      @(posedge clk_i);
    end while (!go);
    items_sent++;
  endtask

  task automatic load_item(input logic [histeq_pkg::IDX_W-1:0] idx,
                           input logic [histeq_pkg::CNT_W-1:0] cnt);
    push_item(histeq_pkg::OP_LOAD, idx, cnt);
    written[idx] = 1'b1;
    any_written  = 1'b1;
    last_loaded  = idx;
  endtask

  // once any bin is loaded, queries of entries never loaded go to the last loaded bin
  task automatic query_item(input logic [histeq_pkg::IDX_W-1:0] idx);
    if (any_written && !written[idx]) idx = last_loaded;
    push_item(histeq_pkg::OP_QUERY, idx, $urandom);
  endtask

  task automatic write_reg(input logic [histeq_pkg::CFG_IDX_W-1:0] ridx,
                           input logic [histeq_pkg::DIM_W-1:0] data);
    bit go;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
  endtask

  task automatic configure(input logic [histeq_pkg::DIM_W-1:0] w,
                           input logic [histeq_pkg::DIM_W-1:0] h);
    write_reg(histeq_pkg::REG_WIDTH, w);
    write_reg(histeq_pkg::REG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic build_histogram(input hist_kind_e kind, input int len);
    logic [histeq_pkg::CNT_W-1:0] total;
    logic [histeq_pkg::CNT_W-1:0] remaining;
    logic [histeq_pkg::CNT_W-1:0] cnt;
    int                           lead;
    total     = histeq_pkg::CNT_W'(frame_w) * histeq_pkg::CNT_W'(frame_h);
    remaining = total;
    lead      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1)
                                            : $urandom_range(0, (len > 4) ? 3 : len - 1);
    for (int i = 0; i < len; i++) begin
      case (kind)
        HIST_SPREAD: begin
          if (i < lead) begin
            cnt = '0;
          end else if (i == len - 1) begin
            cnt = remaining;
          end else if (remaining == '0 || $urandom_range(0, 3) == 0) begin
            cnt = '0;
          end else begin
            cnt = $urandom_range(0, remaining >> $urandom_range(0, 8));
          end
          remaining = remaining - cnt;
        end
        HIST_SINGLE: begin
          cnt = (i == lead) ? total : '0;
        end
        HIST_NOISE: begin
          cnt = ($urandom_range(0, 3) == 0) ? '0 : histeq_pkg::CNT_W'($urandom);
        end
        default: begin
          cnt = '0;
        end
      endcase
      if (kind == HIST_BROKEN) begin
        load_item(histeq_pkg::IDX_W'($urandom_range(0, histeq_pkg::LEVELS - 1)),
                  ($urandom_range(0, 2) == 0) ? '0 : $urandom);
      end else begin
        load_item(histeq_pkg::IDX_W'(i), cnt);
      end
    end
  endtask

  initial begin
    int         pick;
    int         len;
    int         queries;
    hist_kind_e kind;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing loaded yet
    query_item('0);
    query_item(histeq_pkg::MAX_LEVEL);
    settle();

    // small frame, first bin at 1
    configure(histeq_pkg::DIM_W'(4), histeq_pkg::DIM_W'(2));
    load_item(histeq_pkg::IDX_W'(0), 32'd0);
    load_item(histeq_pkg::IDX_W'(1), 32'd3);
    load_item(histeq_pkg::IDX_W'(2), 32'd0);
    load_item(histeq_pkg::IDX_W'(3), 32'd5);
    query_item(histeq_pkg::IDX_W'(1));
    query_item(histeq_pkg::IDX_W'(2));
    query_item(histeq_pkg::IDX_W'(3));
    settle();

    // largest frame, first count above the total, then a restart
    configure(histeq_pkg::DIM_W'(16'hFFFF), histeq_pkg::DIM_W'(16'hFFFF));
    load_item(histeq_pkg::IDX_W'(0), 32'd0);
    load_item(histeq_pkg::IDX_W'(1), 32'hFFFF_FFFF);
    load_item(histeq_pkg::IDX_W'(2), 32'hFFFF_FFFF);
    query_item(histeq_pkg::IDX_W'(2));
    load_item(histeq_pkg::IDX_W'(0), 32'd5);
    load_item(histeq_pkg::IDX_W'(1), 32'hFFFD_FFFA);
    load_item(histeq_pkg::IDX_W'(2), 32'd2);
    load_item(histeq_pkg::MAX_LEVEL, 32'd1);
    query_item(histeq_pkg::IDX_W'(0));
    query_item(histeq_pkg::IDX_W'(1));
    query_item(histeq_pkg::IDX_W'(2));
    query_item(histeq_pkg::MAX_LEVEL);
    settle();

    // single-pixel frame held by one bin
    configure(histeq_pkg::DIM_W'(1), histeq_pkg::DIM_W'(1));
    load_item(histeq_pkg::IDX_W'(0), 32'd0);
    load_item(histeq_pkg::IDX_W'(1), 32'd1);
    query_item(histeq_pkg::IDX_W'(0));
    query_item(histeq_pkg::IDX_W'(1));

    while (items_sent < ITEM_TARGET) begin
      settle();
      calm       = (items_sent >= CALM_AFTER);
      gap_rate   = calm ? 0 : $urandom_range(0, 4);
      stall_rate = calm ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 6))
          0: configure(histeq_pkg::DIM_W'(1), histeq_pkg::DIM_W'(1));
          1: configure(histeq_pkg::DIM_W'(16'hFFFF), histeq_pkg::DIM_W'(16'hFFFF));
          2: configure(histeq_pkg::DIM_W'(1), histeq_pkg::DIM_W'(16'hFFFF));
          3: configure(histeq_pkg::DIM_W'(0), histeq_pkg::DIM_W'($urandom));
          4, 5: configure(histeq_pkg::DIM_W'($urandom_range(1, 64)),
                          histeq_pkg::DIM_W'($urandom_range(1, 64)));
          default: configure(histeq_pkg::DIM_W'($urandom), histeq_pkg::DIM_W'($urandom));
        endcase
      end
      pick = $urandom_range(0, 9);
      kind = (pick <= 5) ? HIST_SPREAD :
             (pick == 6) ? HIST_SINGLE :
             (pick == 7) ? HIST_EMPTY  :
             (pick == 8) ? HIST_NOISE  : HIST_BROKEN;
      if (kind == HIST_BROKEN) begin
        len = $urandom_range(1, 40);
      end else begin
        len = ($urandom_range(0, 1) == 0) ? histeq_pkg::LEVELS
                                          : $urandom_range(1, histeq_pkg::LEVELS);
      end
      build_histogram(kind, len);
      queries = $urandom_range(10, 60);
      for (int q = 0; q < queries; q++) begin
        if ($urandom_range(0, 24) == 0) begin
          load_item(histeq_pkg::IDX_W'($urandom_range(0, histeq_pkg::LEVELS - 1)), $urandom);
        end else begin
          query_item(histeq_pkg::IDX_W'($urandom_range(0, histeq_pkg::LEVELS - 1)));
        end
      end
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("** histogram_equalization_table_core: PASSED **");
    end else begin
      $display("** histogram_equalization_table_core: FAILED **");
    end
    $finish;
  end

endmodule
